@@ sv/kmcd_pkg.sv @@
package kmcd_pkg;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] key_row;
        logic [1:0] key_col;
        logic       key_down;
    } t_in_item;

    typedef struct packed {
        logic [4:0] scan_code;
        logic [2:0] event_row;
        logic [1:0] event_col;
        logic       now_pressed;
        logic       is_sync;
        logic       last_of_run;
    } t_out_item;

    localparam logic [1:0] FUNC_BEGIN  = 2'd0;
    localparam logic [1:0] FUNC_REPORT = 2'd1;
    localparam logic [1:0] FUNC_END    = 2'd2;
    localparam logic [1:0] FUNC_FAIL   = 2'd3;

    localparam logic CFG_KEY_ROWS = 1'b0;
    localparam logic CFG_KEY_COLS = 1'b1;

    localparam logic [3:0] KEY_ROWS_RST = 4'd8;
    localparam logic [2:0] KEY_COLS_RST = 3'd4;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_SET,
        OP_END
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] key_row;
        logic [1:0] key_col;
        logic       key_down;
    } t_cmd;

    typedef struct packed {
        logic [3:0] rows;
        logic [2:0] cols;
    } t_geom;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_SYNC
    } t_walk_state;

    // Row shift of the scan code: the smallest s with 2**s >= cols.
    function automatic logic [1:0] code_shift(input logic [2:0] cols);
        logic [1:0] s;
        s = 2'd0;
        if (cols > 3'd1) begin
            s = 2'd1;
        end
        if (cols > 3'd2) begin
            s = 2'd2;
        end
        if (cols > 3'd4) begin
            s = 2'd3;
        end
        return s;
    endfunction

endpackage

@@ sv/kmcd_front.sv @@
module kmcd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kmcd_pkg::t_in_item  i_in_item,
    input  kmcd_pkg::t_geom     i_geom,
    output logic                o_cmd_valid,
    output kmcd_pkg::t_cmd      o_cmd,
    input  logic                i_cmd_pop
);

    kmcd_pkg::t_cmd r_q [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    logic           accept;
    logic           range_ok;
    logic           push;
    logic           pop;
    kmcd_pkg::t_cmd cmd;

    assign o_in_ready  = (r_count != 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign accept      = i_in_valid && o_in_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        range_ok     = ({1'b0, i_in_item.key_row} < i_geom.rows)
                    && ({1'b0, i_in_item.key_col} < i_geom.cols);
        cmd.key_row  = i_in_item.key_row;
        cmd.key_col  = i_in_item.key_col;
        cmd.key_down = i_in_item.key_down;
        push         = accept;
        unique case (i_in_item.func) inside
            kmcd_pkg::FUNC_BEGIN, kmcd_pkg::FUNC_FAIL: begin
                cmd.op = kmcd_pkg::OP_CLEAR;
            end
            kmcd_pkg::FUNC_REPORT: begin
                cmd.op = kmcd_pkg::OP_SET;
                push   = accept && range_ok;
            end
            default: begin
                cmd.op = kmcd_pkg::OP_END;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

@@ sv/kmcd_back.sv @@
module kmcd_back #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  kmcd_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  kmcd_pkg::t_geom     i_geom,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kmcd_pkg::t_out_item o_out_item
);

    localparam int NBITS = MAX_ROWS * MAX_COLS;
    localparam int IDX_W = (NBITS > 1) ? $clog2(NBITS) : 1;
    localparam int LIN_W = (IDX_W > 7) ? IDX_W : 7;

    kmcd_pkg::t_walk_state r_state, n_state;
    logic [NBITS-1:0]      r_cur, n_cur;
    logic [NBITS-1:0]      r_prev, n_prev;
    logic [IDX_W-1:0]      r_bit, n_bit;
    logic [3:0]            r_row, n_row;
    logic [2:0]            r_col, n_col;
    logic                  r_out_valid, n_out_valid;
    kmcd_pkg::t_out_item   r_out, n_out;

    logic [LIN_W-1:0]      lin;
    logic [IDX_W-1:0]      set_idx;
    logic                  step_ok;
    logic                  last_key;
    logic                  changed;
    logic [7:0]            code_sum;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        lin      = LIN_W'(i_cmd.key_row) * LIN_W'(i_geom.cols) + LIN_W'(i_cmd.key_col);
        set_idx  = lin[IDX_W-1:0];
        step_ok  = !r_out_valid || i_out_ready;
        last_key = (r_row == i_geom.rows - 4'd1) && (r_col == i_geom.cols - 3'd1);
        changed  = r_cur[r_bit] ^ r_prev[r_bit];
        code_sum = (8'(r_row) << kmcd_pkg::code_shift(i_geom.cols)) + 8'(r_col);

        n_state     = r_state;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_bit       = r_bit;
        n_row       = r_row;
        n_col       = r_col;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;

        unique case (r_state)
            kmcd_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        kmcd_pkg::OP_CLEAR: begin
                            n_cur = '0;
                        end
                        kmcd_pkg::OP_SET: begin
                            n_cur[set_idx] = i_cmd.key_down;
                        end
                        default: begin
                            n_state = kmcd_pkg::ST_WALK;
                            n_bit   = '0;
                            n_row   = 4'd0;
                            n_col   = 3'd0;
                        end
                    endcase
                end
            end
            kmcd_pkg::ST_WALK: begin
                if (step_ok) begin
                    n_prev[r_bit] = r_cur[r_bit];
                    if (changed) begin
                        n_out_valid           = 1'b1;
                        n_out.scan_code       = code_sum[4:0];
                        n_out.event_row       = r_row[2:0];
                        n_out.event_col       = r_col[1:0];
                        n_out.now_pressed     = r_cur[r_bit];
                        n_out.is_sync         = 1'b0;
                        n_out.last_of_run     = 1'b0;
                    end
                    if (last_key) begin
                        n_state = kmcd_pkg::ST_SYNC;
                    end else begin
                        n_bit = r_bit + IDX_W'(1);
                        if (r_col == i_geom.cols - 3'd1) begin
                            n_col = 3'd0;
                            n_row = r_row + 4'd1;
                        end else begin
                            n_col = r_col + 3'd1;
                        end
                    end
                end
            end
            default: begin
                if (step_ok) begin
                    n_out_valid       = 1'b1;
                    n_out.scan_code   = 5'd0;
                    n_out.event_row   = 3'd0;
                    n_out.event_col   = 2'd0;
                    n_out.now_pressed = 1'b0;
                    n_out.is_sync     = 1'b1;
                    n_out.last_of_run = 1'b1;
                    n_state           = kmcd_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kmcd_pkg::ST_IDLE;
            r_cur       <= '0;
            r_prev      <= '0;
            r_bit       <= '0;
            r_row       <= 4'd0;
            r_col       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_prev      <= n_prev;
            r_bit       <= n_bit;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

@@ sv/keypad_matrix_change_detector.sv @@
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_in_item  (kmcd_pkg::t_in_item)
// output    out        o_out_valid / i_out_ready   o_out_item (kmcd_pkg::t_out_item)
// config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
// Begin and scan-failed items clear the current key map; a report item in range sets or clears one key bit.
// An end-scan item starts a walk: each key bit is compared with the previous map, then a sync item follows.
// A two-entry command queue lets the input side keep accepting during a walk.
// The walk pauses while the output register holds an item that is not taken.
// Synchronous reset clears both maps, the queue and the output valid flag and sets 8 rows, 4 columns.
module keypad_matrix_change_detector #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kmcd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kmcd_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [3:0]          i_cfg_data
);

    localparam logic [4:0] MAX_ROWS_W = 5'(MAX_ROWS);
    localparam logic [4:0] MAX_COLS_W = 5'(MAX_COLS);

    logic [3:0]      r_key_rows;
    logic [2:0]      r_key_cols;
    kmcd_pkg::t_geom geom;
    logic            cmd_valid;
    logic            cmd_pop;
    kmcd_pkg::t_cmd  cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_rows <= kmcd_pkg::KEY_ROWS_RST;
            r_key_cols <= kmcd_pkg::KEY_COLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kmcd_pkg::CFG_KEY_ROWS: r_key_rows <= i_cfg_data;
                default:                r_key_cols <= i_cfg_data[2:0];
            endcase
        end
    end

    always_comb begin
        if (r_key_rows == 4'd0) begin
            geom.rows = 4'd1;
        end else if ({1'b0, r_key_rows} > MAX_ROWS_W) begin
            geom.rows = MAX_ROWS_W[3:0];
        end else begin
            geom.rows = r_key_rows;
        end
        if (r_key_cols == 3'd0) begin
            geom.cols = 3'd1;
        end else if ({2'b0, r_key_cols} > MAX_COLS_W) begin
            geom.cols = MAX_COLS_W[2:0];
        end else begin
            geom.cols = r_key_cols;
        end
    end

    kmcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_geom      (geom),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    kmcd_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_geom      (geom),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ sv/kmcd_checker.sv @@
module kmcd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input kmcd_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input kmcd_pkg::t_out_item o_out_item
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output item valid right after reset");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("waiting input item dropped or changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item dropped or changed");

    a_sync_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_sync |->
            o_out_item.scan_code == 5'd0 && o_out_item.event_row == 3'd0
            && o_out_item.event_col == 2'd0 && !o_out_item.now_pressed)
        else $error("sync item carries key fields");

    a_last_is_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.is_sync == o_out_item.last_of_run)
        else $error("last mark and sync mark disagree");

endmodule

bind keypad_matrix_change_detector kmcd_checker u_kmcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

@@ bench/tb_keypad_matrix_change_detector.sv @@
`timescale 1ns / 1ps

module tb_keypad_matrix_change_detector;

    localparam int KEY_ROWS_MAX   = 8;
    localparam int KEY_COLS_MAX   = 4;
    localparam int N_PHASES       = 8;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WALK_SETTLE    = 48;
    localparam int IDLE_LIMIT     = 4000;

    typedef enum int {
        RX_ALWAYS,
        RX_ONE_IN_FOUR,
        RX_HALF,
        RX_MOSTLY
    } t_rx_mode;

    class key_event_scoreboard;
        logic [31:0]         cur_map;
        logic [31:0]         prev_map;
        logic [3:0]          rows_reg;
        logic [2:0]          cols_reg;
        kmcd_pkg::t_out_item key_events_q[$];
        int                  errors;

        function new();
            cur_map  = '0;
            prev_map = '0;
            rows_reg = kmcd_pkg::KEY_ROWS_RST;
            cols_reg = kmcd_pkg::KEY_COLS_RST;
            errors   = 0;
        endfunction

        function void write_reg(logic idx, logic [3:0] data);
            if (idx == kmcd_pkg::CFG_KEY_ROWS) begin
                rows_reg = data;
            end else begin
                cols_reg = data[2:0];
            end
        endfunction

        function int unsigned eff_rows();
            if (rows_reg == 0) begin
                return 1;
            end
            if (rows_reg > KEY_ROWS_MAX) begin
                return KEY_ROWS_MAX;
            end
            return 32'(rows_reg);
        endfunction

        function int unsigned eff_cols();
            if (cols_reg == 0) begin
                return 1;
            end
            if (cols_reg > KEY_COLS_MAX) begin
                return KEY_COLS_MAX;
            end
            return 32'(cols_reg);
        endfunction

        function int pending();
            return key_events_q.size();
        endfunction

        function void note_scan_item(kmcd_pkg::t_in_item it);
            int unsigned         nrows;
            int unsigned         ncols;
            int unsigned         nbits;
            int unsigned         shift;
            int unsigned         r;
            int unsigned         c;
            int unsigned         b;
            kmcd_pkg::t_out_item ev;
            nrows = eff_rows();
            ncols = eff_cols();
            nbits = nrows * ncols;
            case (it.func)
                kmcd_pkg::FUNC_BEGIN, kmcd_pkg::FUNC_FAIL: begin
                    cur_map = '0;
                end
                kmcd_pkg::FUNC_REPORT: begin
                    if (it.key_row < nrows && it.key_col < ncols) begin
                        cur_map[it.key_row * ncols + it.key_col] = it.key_down;
                    end
                end
                kmcd_pkg::FUNC_END: begin
                    shift = 0;
                    while ((1 << shift) < ncols) begin
                        shift++;
                    end
                    for (b = 0; b < nbits; b++) begin
                        if (cur_map[b] != prev_map[b]) begin
                            r              = b / ncols;
                            c              = b % ncols;
                            ev             = '0;
                            ev.scan_code   = 5'((r << shift) + c);
                            ev.event_row   = 3'(r);
                            ev.event_col   = 2'(c);
                            ev.now_pressed = cur_map[b];
                            key_events_q.push_back(ev);
                        end
                    end
                    ev             = '0;
                    ev.is_sync     = 1'b1;
                    ev.last_of_run = 1'b1;
                    key_events_q.push_back(ev);
                    for (b = 0; b < nbits; b++) begin
                        prev_map[b] = cur_map[b];
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
            if (act_val !== exp_val) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            end
        endfunction

        function void check_key_event(kmcd_pkg::t_out_item got);
            kmcd_pkg::t_out_item exp_ev;
            if (key_events_q.size() == 0) begin
                errors++;
                $error("unexpected key event result: %p", got);
                return;
            end
            exp_ev = key_events_q.pop_front();
            compare_field("scan_code", 8'(exp_ev.scan_code), 8'(got.scan_code));
            compare_field("event_row", 8'(exp_ev.event_row), 8'(got.event_row));
            compare_field("event_col", 8'(exp_ev.event_col), 8'(got.event_col));
            compare_field("now_pressed", 8'(exp_ev.now_pressed), 8'(got.now_pressed));
            compare_field("is_sync", 8'(exp_ev.is_sync), 8'(got.is_sync));
            compare_field("last_of_run", 8'(exp_ev.last_of_run), 8'(got.last_of_run));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    kmcd_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    kmcd_pkg::t_out_item o_out_item;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [3:0]          i_cfg_data;

    key_event_scoreboard sb = new();

    bit         hold_req = 1'b0;
    bit         gaps_on = 1'b1;
    int         burst_left = 0;
    int         items_counted = 0;
    int         stall_cycles = 0;
    logic [3:0] phase_rows [N_PHASES] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd7, 4'd8};
    logic [3:0] phase_cols [N_PHASES] = '{4'd4, 4'd1, 4'd0, 4'd7, 4'd3, 4'd2, 4'd14, 4'd4};

    keypad_matrix_change_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_scan_item(i_in_item);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_key_event(o_out_item);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        int       rx_tick;
        i_out_ready = 1'b0;
        rx_mode     = RX_ALWAYS;
        mode_left   = 0;
        rx_tick     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 100);
            end
            mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_ALWAYS:      i_out_ready <= 1'b1;
                RX_ONE_IN_FOUR: i_out_ready <= (rx_tick % 4 == 0);
                RX_HALF:        i_out_ready <= 1'($urandom_range(0, 1));
                default:        i_out_ready <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    function automatic kmcd_pkg::t_in_item key_item(logic [1:0] func, logic [2:0] row,
                                                    logic [1:0] col, logic down);
        kmcd_pkg::t_in_item it;
        it.func     = func;
        it.key_row  = row;
        it.key_col  = col;
        it.key_down = down;
        return it;
    endfunction

    task automatic idle_cycles(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic offer(kmcd_pkg::t_in_item it);
        if (burst_left == 0) begin
            if (gaps_on) begin
                idle_cycles($urandom_range(1, 8));
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        items_counted++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic set_geometry(logic [3:0] rows_data, logic [3:0] cols_data);
        wait_drained();
        repeat (WALK_SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= kmcd_pkg::CFG_KEY_ROWS;
        i_cfg_data  <= rows_data;
        @(negedge i_clk);
        i_cfg_index <= kmcd_pkg::CFG_KEY_COLS;
        i_cfg_data  <= cols_data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_scan(int n_reports);
        logic [2:0] row;
        logic [1:0] col;
        offer(key_item(kmcd_pkg::FUNC_BEGIN, 3'($urandom), 2'($urandom), 1'($urandom)));
        repeat (n_reports) begin
            if ($urandom_range(0, 99) < 80) begin
                row = 3'($urandom_range(0, sb.eff_rows() - 1));
                col = 2'($urandom_range(0, sb.eff_cols() - 1));
            end else begin
                row = 3'($urandom_range(0, 7));
                col = 2'($urandom_range(0, 3));
            end
            offer(key_item(kmcd_pkg::FUNC_REPORT, row, col, $urandom_range(0, 99) < 85));
        end
        if ($urandom_range(0, 9) == 0) begin
            offer(key_item(kmcd_pkg::FUNC_FAIL, 3'($urandom), 2'($urandom), 1'($urandom)));
        end else begin
            offer(key_item(kmcd_pkg::FUNC_END, 3'($urandom), 2'($urandom), 1'($urandom)));
        end
    endtask

    task automatic random_stimulus(int target);
        bit drained;
        drained = 1'b0;
        while (items_counted < target) begin
            if ($urandom_range(0, 3) != 0) begin
                send_scan($urandom_range(0, 10));
            end else begin
                offer(kmcd_pkg::t_in_item'(8'($urandom_range(0, 255))));
            end
            if (!drained && items_counted >= target / 2) begin
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    initial begin
        int p;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = kmcd_pkg::CFG_KEY_ROWS;
        i_cfg_data  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (p = 0; p < N_PHASES; p++) begin
            if (p != 0) begin
                set_geometry(phase_rows[p], phase_cols[p]);
            end
            gaps_on = (p % 3 != 2);
            if (p == 0) begin
                offer(key_item(kmcd_pkg::FUNC_END, 3'd0, 2'd0, 1'b0));
                offer(key_item(kmcd_pkg::FUNC_BEGIN, 3'd0, 2'd0, 1'b0));
                offer(key_item(kmcd_pkg::FUNC_REPORT, 3'd0, 2'd0, 1'b1));
                offer(key_item(kmcd_pkg::FUNC_REPORT, 3'd7, 2'd3, 1'b1));
                offer(key_item(kmcd_pkg::FUNC_REPORT, 3'd2, 2'd1, 1'b1));
                offer(key_item(kmcd_pkg::FUNC_REPORT, 3'd2, 2'd1, 1'b0));
                offer(key_item(kmcd_pkg::FUNC_END, 3'd7, 2'd3, 1'b1));
                offer(key_item(kmcd_pkg::FUNC_BEGIN, 3'd7, 2'd3, 1'b1));
                offer(key_item(kmcd_pkg::FUNC_REPORT, 3'd7, 2'd3, 1'b1));
                offer(key_item(kmcd_pkg::FUNC_REPORT, 3'd4, 2'd2, 1'b1));
                offer(key_item(kmcd_pkg::FUNC_FAIL, 3'd0, 2'd0, 1'b0));
                offer(key_item(kmcd_pkg::FUNC_END, 3'd0, 2'd0, 1'b0));
                offer(key_item(kmcd_pkg::FUNC_REPORT, 3'd5, 2'd1, 1'b1));
                offer(key_item(kmcd_pkg::FUNC_END, 3'd0, 2'd0, 1'b0));
                offer(key_item(kmcd_pkg::FUNC_BEGIN, 3'd0, 2'd0, 1'b0));
                offer(key_item(kmcd_pkg::FUNC_REPORT, 3'd3, 2'd2, 1'b1));
                offer(key_item(kmcd_pkg::FUNC_REPORT, 3'd6, 2'd1, 1'b0));
                offer(key_item(kmcd_pkg::FUNC_BEGIN, 3'd0, 2'd0, 1'b0));
                offer(key_item(kmcd_pkg::FUNC_REPORT, 3'd1, 2'd3, 1'b1));
                offer(key_item(kmcd_pkg::FUNC_END, 3'd0, 2'd0, 1'b0));

                hold_req = 1'b1;
                gaps_on  = 1'b0;
                repeat (4) send_scan(8);
                gaps_on  = 1'b1;
            end
            if (p == 4) begin
                offer(key_item(kmcd_pkg::FUNC_BEGIN, 3'd0, 2'd0, 1'b0));
                offer(key_item(kmcd_pkg::FUNC_REPORT, 3'd3, 2'd0, 1'b1));
                offer(key_item(kmcd_pkg::FUNC_REPORT, 3'd0, 2'd3, 1'b1));
                offer(key_item(kmcd_pkg::FUNC_REPORT, 3'd2, 2'd2, 1'b1));
                offer(key_item(kmcd_pkg::FUNC_END, 3'd0, 2'd0, 1'b0));
            end
            items_counted = 0;
            random_stimulus(p == 0 ? 15 : 20);
        end

        wait_drained();
        repeat (WALK_SETTLE) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
